// File: hw/rtl/prct_pkg.sv
// package for the page reference count table: request and status codes, shared types
`default_nettype none
package prct_pkg;
	localparam int ENTRIES_DEF = 32;
	localparam int PAGE_BITS_DEF = 20;
	localparam int COUNT_BITS_DEF = 16;
	localparam int REQ_W = 3;
	localparam int STAT_W = 3;
	localparam int PAGE_W = 20;
	localparam int CNT_W = 16;

	typedef enum logic [REQ_W-1:0] {
		REQ_INIT = 3'd0,
		REQ_REGISTER = 3'd1,
		REQ_QUERY = 3'd2,
		REQ_REF = 3'd3,
		REQ_UNREF = 3'd4,
		REQ_SHARE = 3'd5,
		REQ_RELEASE = 3'd6,
		REQ_NONE = 3'd7
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_FULL = 3'd2,
		ST_DUP = 3'd3,
		ST_RANGE = 3'd4
	} stat_t;

	typedef enum logic [1:0] {
		EX_IDLE = 2'd0,
		EX_WALK = 2'd1,
		EX_FINAL = 2'd2
	} ex_state_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic found;
		logic [CNT_W-1:0] ref_count;
		logic free_valid;
		logic [PAGE_W-1:0] free_page;
		logic last;
	} res_t;
endpackage
`default_nettype wire

// File: hw/rtl/prct_front.sv
// front part: request queue of depth two between the input side and the table
`default_nettype none
module prct_front import prct_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [REQ_W-1:0] req_type,
	input wire logic [PAGE_W-1:0] page_number,
	input wire logic fixed_flag,
	output logic cmd_valid,
	input wire logic cmd_take,
	output logic [REQ_W-1:0] cmd_req,
	output logic [PAGE_W-1:0] cmd_page,
	output logic cmd_fixed
);
	localparam int W = REQ_W + PAGE_W + 1;
	logic [W-1:0] mem_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic do_push, do_pop;

	assign full = cnt_q[1];
	assign cmd_valid = cnt_q != 2'd0;
	assign do_push = push && !full;
	assign do_pop = cmd_take && cmd_valid;
	assign {cmd_req, cmd_page, cmd_fixed} = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= {req_type, page_number, fixed_flag};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (!do_push && do_pop) cnt_q <= cnt_q - 2'd1;
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/prct_exec.sv
// back part: the table, its lookup and update, and the bulk walk
`default_nettype none
module prct_exec import prct_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	output logic cmd_take,
	input wire logic [REQ_W-1:0] cmd_req,
	input wire logic [PAGE_W-1:0] cmd_page,
	input wire logic cmd_fixed,
	output logic res_valid,
	input wire logic res_ready,
	output res_t res
);
	localparam int IW = $clog2(ENTRIES);
	localparam int PB = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	logic [ENTRIES-1:0] valid_q;
	logic [PAGE_BITS-1:0] page_q [ENTRIES];
	logic [ENTRIES-1:0] fixed_q;
	logic [COUNT_BITS-1:0] cnt_q [ENTRIES];

	ex_state_t state_q, state_d;
	req_t op_q, op_d;
	logic [IW-1:0] walk_q;
	logic [STAT_W-1:0] wstat_q, wstat_d;

	logic out_v_q, out_v_d;
	res_t out_q, out_d;
	logic out_free;
	logic fin_load;

	logic [PAGE_BITS-1:0] key;
	logic [ENTRIES-1:0] hit;
	logic any_hit, any_free;
	logic [IW-1:0] hit_idx, free_idx;
	logic [COUNT_BITS-1:0] hc;
	res_t single;
	logic single_wr;
	logic [COUNT_BITS-1:0] single_cnt;
	logic [COUNT_BITS-1:0] wc;
	logic walk_free, walk_wr;
	logic [COUNT_BITS-1:0] walk_cnt;
	logic walk_bad, walk_end;
	logic start, walk_step;

	assign out_free = !out_v_q || res_ready;
	assign res_valid = out_v_q;
	assign res = out_q;

	always_comb begin
		key = '0;
		key[PB-1:0] = cmd_page[PB-1:0];
		for (int i = 0; i < ENTRIES; i++) hit[i] = valid_q[i] && page_q[i] == key;
	end

	always_comb begin
		hit_idx = '0;
		free_idx = '0;
		any_hit = 1'b0;
		any_free = 1'b0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (hit[i]) begin
				hit_idx = IW'(i);
				any_hit = 1'b1;
			end
			if (!valid_q[i]) begin
				free_idx = IW'(i);
				any_free = 1'b1;
			end
		end
	end

	assign hc = cnt_q[hit_idx];

	function automatic logic [CNT_W-1:0] cext(input logic [COUNT_BITS-1:0] c);
		logic [CNT_W+COUNT_BITS-1:0] t;
		t = {{CNT_W{1'b0}}, c};
		return t[CNT_W-1:0];
	endfunction

	function automatic logic [PAGE_W-1:0] pext(input logic [PAGE_BITS-1:0] p);
		logic [PAGE_W+PAGE_BITS-1:0] t;
		t = {{PAGE_W{1'b0}}, p};
		return t[PAGE_W-1:0];
	endfunction

	// single request result; an unreference that frees goes on to the final state instead
	always_comb begin
		single = '0;
		single.last = 1'b1;
		single_wr = 1'b0;
		single_cnt = hc;
		unique case (cmd_req)
			REQ_REGISTER: begin
				if (any_hit) begin
					single.status = ST_DUP;
					single.found = 1'b1;
					single.ref_count = cext(hc);
				end else if (!any_free) begin
					single.status = ST_FULL;
				end else begin
					single.found = 1'b1;
					single.ref_count = 16'd1;
				end
			end
			REQ_QUERY, REQ_REF, REQ_UNREF: begin
				if (!any_hit) begin
					single.status = ST_NOT_FOUND;
				end else begin
					single.found = 1'b1;
					single.ref_count = cext(hc);
					if (cmd_req == REQ_REF) begin
						if (hc == CMAX) single.status = ST_RANGE;
						else begin
							single_wr = 1'b1;
							single_cnt = hc + 1'b1;
						end
					end else if (cmd_req == REQ_UNREF) begin
						if (hc == '0) single.status = ST_RANGE;
						else begin
							single_wr = 1'b1;
							single_cnt = hc - 1'b1;
						end
					end
					single.ref_count = cext(single_cnt);
				end
			end
			default: ;
		endcase
	end

	// one entry per cycle during a bulk walk, while the output register is free
	assign wc = cnt_q[walk_q];
	always_comb begin
		walk_free = 1'b0;
		walk_wr = 1'b0;
		walk_bad = 1'b0;
		walk_cnt = wc;
		if (valid_q[walk_q]) begin
			if (op_q == REQ_SHARE) begin
				if (wc == CMAX) walk_bad = 1'b1;
				else begin
					walk_wr = 1'b1;
					walk_cnt = wc + 1'b1;
				end
			end else begin
				if (wc == '0) walk_bad = 1'b1;
				else begin
					walk_wr = 1'b1;
					walk_cnt = wc - 1'b1;
					walk_free = walk_cnt == '0 && !fixed_q[walk_q];
				end
			end
		end
	end
	assign walk_end = walk_q == IW'(ENTRIES - 1);

	assign start = state_q == EX_IDLE && cmd_valid && out_free;
	assign walk_step = state_q == EX_WALK && out_free;
	assign fin_load = state_q == EX_FINAL && out_free;
	assign cmd_take = start;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			EX_IDLE: if (start && (cmd_req == REQ_SHARE || cmd_req == REQ_RELEASE
					|| (cmd_req == REQ_UNREF && any_hit && hc == COUNT_BITS'(1)
					&& !fixed_q[hit_idx])))
				state_d = (cmd_req == REQ_UNREF) ? EX_FINAL : EX_WALK;
			EX_WALK: if (walk_step && walk_end) state_d = EX_FINAL;
			EX_FINAL: if (out_free) state_d = EX_IDLE;
			default: state_d = EX_IDLE;
		endcase
	end

	// next value of the output register and the walk status
	always_comb begin
		out_v_d = out_v_q && !res_ready;
		out_d = out_q;
		op_d = op_q;
		wstat_d = wstat_q;
		if (start) begin
			op_d = req_t'(cmd_req);
			wstat_d = ST_OK;
			out_d = single;
			if (state_d == EX_IDLE) out_v_d = 1'b1;
			if (state_d == EX_FINAL) begin
				// freed page first, then the final result
				op_d = REQ_UNREF;
				out_d = '0;
				out_d.free_valid = 1'b1;
				out_d.free_page = pext(page_q[hit_idx]);
				wstat_d = single.status;
				out_v_d = 1'b1;
			end
		end
		if (walk_step) begin
			if (walk_bad) wstat_d = ST_RANGE;
			if (walk_free) begin
				out_d = '0;
				out_d.free_valid = 1'b1;
				out_d.free_page = pext(page_q[walk_q]);
				out_v_d = 1'b1;
			end
		end
		if (fin_load) begin
			out_d = '0;
			out_d.status = wstat_q;
			out_d.last = 1'b1;
			out_d.found = op_q == REQ_UNREF;
			out_v_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
			valid_q <= '0;
			walk_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_v_q <= out_v_d;
			if (start) begin
				walk_q <= '0;
				if (cmd_req == REQ_INIT) valid_q <= '0;
				if (cmd_req == REQ_REGISTER && !any_hit && any_free)
					valid_q[free_idx] <= 1'b1;
			end
			if (walk_step) walk_q <= walk_end ? '0 : walk_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		wstat_q <= wstat_d;
		out_q <= out_d;
		if (start) begin
			if (cmd_req == REQ_REGISTER && !any_hit && any_free) begin
				page_q[free_idx] <= key;
				fixed_q[free_idx] <= cmd_fixed;
				cnt_q[free_idx] <= COUNT_BITS'(1);
			end
			if (single_wr) cnt_q[hit_idx] <= single_cnt;
		end
		if (walk_step && walk_wr) cnt_q[walk_q] <= walk_cnt;
	end
endmodule
`default_nettype wire

// File: hw/rtl/page_reference_count_table.sv
// Page reference count table: table of pages with reference counts, matched by page number.
// Requests enter through push/full and wait in a two-deep queue. The back end takes one
// request at a time. Results leave through empty/pop from a one-entry output register.
// Single lookups (register, query, reference, unreference) compare all entries at once and
// put their result on the ports in the cycle after the request is accepted; with pop held
// high the back end takes a new request every cycle.
// An unreference that frees a page gives the free result and then the final one.
// Share all and release all walk the table one entry per cycle while the output is free,
// giving a free result for every freed page and then the final result.
// While pop stays low the result stays on the ports and the back end holds; the
// front queue still takes up to two requests.
// Reset clears all valid bits and the queues; no clearing pass is needed.
`default_nettype none
module page_reference_count_table import prct_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [REQ_W-1:0] req_type,
	input wire logic [PAGE_W-1:0] page_number,
	input wire logic fixed_flag,
	output logic empty,
	input wire logic pop,
	output logic [STAT_W-1:0] status,
	output logic found,
	output logic [CNT_W-1:0] ref_count,
	output logic free_valid,
	output logic [PAGE_W-1:0] free_page,
	output logic last
);
	logic cmd_valid, cmd_take, cmd_fixed, res_valid;
	logic [REQ_W-1:0] cmd_req;
	logic [PAGE_W-1:0] cmd_page;
	res_t res;

	prct_front u_front (
		.clk, .arst_n, .push, .full, .req_type, .page_number, .fixed_flag,
		.cmd_valid, .cmd_take, .cmd_req, .cmd_page, .cmd_fixed
	);

	prct_exec #(.ENTRIES(ENTRIES), .PAGE_BITS(PAGE_BITS), .COUNT_BITS(COUNT_BITS)) u_exec (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd_req, .cmd_page, .cmd_fixed,
		.res_valid, .res_ready(pop), .res
	);

	assign empty = !res_valid;
	assign status = res.status;
	assign found = res.found;
	assign ref_count = res.ref_count;
	assign free_valid = res.free_valid;
	assign free_page = res.free_page;
	assign last = res.last;

	a_free_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(free_valid && last)) else $error("free result marked last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(status) && $stable(free_page))
		else $error("result changed while stalled");
	a_free_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && free_valid |-> status == ST_OK && !found)
		else $error("free result carries status");
endmodule
`default_nettype wire

// File: tb/sv/tb_page_reference_count_table.sv
// self-checking testbench for the page reference count table: directed, fill, random, short run
`default_nettype none
module tb_page_reference_count_table;
	import prct_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NENT = 32;
	localparam logic [CNT_W-1:0] CNT_TOP = '1;
	localparam int QUIET_LIMIT = 20000;

	typedef struct {
		req_t r;
		logic [PAGE_W-1:0] pg;
		logic fx;
		bit typed;
		stat_t st;
		logic fnd;
		logic [CNT_W-1:0] cnt;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [REQ_W-1:0] req_type;
	logic [PAGE_W-1:0] page_number;
	logic fixed_flag;
	logic empty;
	logic pop;
	logic [STAT_W-1:0] status;
	logic found;
	logic [CNT_W-1:0] ref_count;
	logic free_valid;
	logic [PAGE_W-1:0] free_page;
	logic last;

	page_reference_count_table uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req_type(req_type), .page_number(page_number), .fixed_flag(fixed_flag),
		.empty(empty), .pop(pop), .status(status), .found(found),
		.ref_count(ref_count), .free_valid(free_valid), .free_page(free_page),
		.last(last)
	);

	// shadow copy of the table
	bit tbl_valid [NENT];
	logic [PAGE_W-1:0] tbl_page [NENT];
	bit tbl_fixed [NENT];
	logic [CNT_W-1:0] tbl_count [NENT];

	res_t new_results [$];
	res_t pending_results [$];
	int errors;
	int tx_idle;
	int rx_idle;
	bit hold_off;
	int quiet;
	logic [PAGE_W-1:0] page_pool [40];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic void add_result(stat_t st, logic fnd, logic [CNT_W-1:0] cnt,
			logic fv, logic [PAGE_W-1:0] fp, logic lst);
		res_t r;
		r.status = st;
		r.found = fnd;
		r.ref_count = cnt;
		r.free_valid = fv;
		r.free_page = fp;
		r.last = lst;
		new_results.push_back(r);
	endfunction

	function automatic int find_page(logic [PAGE_W-1:0] pg);
		for (int i = 0; i < NENT; i++)
			if (tbl_valid[i] && tbl_page[i] == pg)
				return i;
		return -1;
	endfunction

	// drop one reference and report the page if it becomes free
	function automatic void drop_ref(int i);
		tbl_count[i] = tbl_count[i] - 1'b1;
		if (tbl_count[i] == 0 && !tbl_fixed[i])
			add_result(ST_OK, 1'b0, '0, 1'b1, tbl_page[i], 1'b0);
	endfunction

	function automatic void table_step(req_t r, logic [PAGE_W-1:0] pg, logic fx);
		int idx;
		stat_t st;
		new_results.delete();
		st = ST_OK;
		case (r)
			REQ_INIT: begin
				for (int i = 0; i < NENT; i++)
					tbl_valid[i] = 0;
				add_result(ST_OK, 1'b0, '0, 1'b0, '0, 1'b1);
			end
			REQ_REGISTER: begin
				idx = find_page(pg);
				if (idx >= 0) begin
					add_result(ST_DUP, 1'b1, tbl_count[idx], 1'b0, '0, 1'b1);
				end else begin
					idx = -1;
					for (int i = NENT - 1; i >= 0; i--)
						if (!tbl_valid[i])
							idx = i;
					if (idx < 0) begin
						add_result(ST_FULL, 1'b0, '0, 1'b0, '0, 1'b1);
					end else begin
						tbl_valid[idx] = 1;
						tbl_page[idx] = pg;
						tbl_fixed[idx] = fx;
						tbl_count[idx] = 1;
						add_result(ST_OK, 1'b1, 16'd1, 1'b0, '0, 1'b1);
					end
				end
			end
			REQ_QUERY, REQ_REF, REQ_UNREF: begin
				idx = find_page(pg);
				if (idx < 0) begin
					add_result(ST_NOT_FOUND, 1'b0, '0, 1'b0, '0, 1'b1);
				end else begin
					if (r == REQ_REF) begin
						if (tbl_count[idx] == CNT_TOP)
							st = ST_RANGE;
						else
							tbl_count[idx]++;
					end else if (r == REQ_UNREF) begin
						if (tbl_count[idx] == 0)
							st = ST_RANGE;
						else
							drop_ref(idx);
					end
					add_result(st, 1'b1, tbl_count[idx], 1'b0, '0, 1'b1);
				end
			end
			REQ_SHARE, REQ_RELEASE: begin
				for (int i = 0; i < NENT; i++) begin
					if (!tbl_valid[i])
						continue;
					if (r == REQ_SHARE) begin
						if (tbl_count[i] == CNT_TOP)
							st = ST_RANGE;
						else
							tbl_count[i]++;
					end else begin
						if (tbl_count[i] == 0)
							st = ST_RANGE;
						else
							drop_ref(i);
					end
				end
				add_result(st, 1'b0, '0, 1'b0, '0, 1'b1);
			end
			default: add_result(ST_OK, 1'b0, '0, 1'b0, '0, 1'b1);
		endcase
	endfunction

	// offer one request and wait until the block takes it
	task automatic send(req_t r, logic [PAGE_W-1:0] pg, logic fx);
		if ($urandom_range(99) < tx_idle) begin
			push <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		push <= 1'b1;
		req_type <= r;
		page_number <= pg;
		fixed_flag <= fx;
		forever begin
			@(posedge clk);
			if (!full)
				break;
		end
		table_step(r, pg, fx);
		foreach (new_results[i])
			pending_results.push_back(new_results[i]);
	endtask

	task automatic send_random();
		int sel;
		logic [PAGE_W-1:0] pg;
		req_t r;
		sel = $urandom_range(99);
		pg = ($urandom_range(9) == 0) ? PAGE_W'($urandom) : page_pool[$urandom_range(39)];
		if (sel < 25) r = REQ_REGISTER;
		else if (sel < 35) r = REQ_QUERY;
		else if (sel < 52) r = REQ_REF;
		else if (sel < 77) r = REQ_UNREF;
		else if (sel < 85) r = REQ_SHARE;
		else if (sel < 95) r = REQ_RELEASE;
		else if (sel < 98) r = REQ_INIT;
		else r = REQ_NONE;
		send(r, pg, 1'($urandom));
	endtask

	// receiver: random pop, with one long hold-off
	initial begin
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				hold_off = 0;
				pop <= 1'b0;
				repeat (300) @(posedge clk);
			end
			pop <= ($urandom_range(99) >= rx_idle);
		end
	end

	// result checker and watchdog; values are the ones from before the edge
	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$error("result with no request waiting");
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, status);
					errors++;
				end
				if (found !== exp_r.found) begin
					$error("found: expected %0d, got %0d", exp_r.found, found);
					errors++;
				end
				if (ref_count !== exp_r.ref_count) begin
					$error("ref_count: expected %0d, got %0d", exp_r.ref_count, ref_count);
					errors++;
				end
				if (free_valid !== exp_r.free_valid) begin
					$error("free_valid: expected %0d, got %0d", exp_r.free_valid, free_valid);
					errors++;
				end
				if (free_page !== exp_r.free_page) begin
					$error("free_page: expected %h, got %h", exp_r.free_page, free_page);
					errors++;
				end
				if (last !== exp_r.last) begin
					$error("last: expected %0d, got %0d", exp_r.last, last);
					errors++;
				end
			end
		end
		if ((push && !full) || (pop && !empty))
			quiet = 0;
		else
			quiet++;
		if (quiet > QUIET_LIMIT) begin
			$display("tb_page_reference_count_table: FAIL");
			$finish;
		end
	end

	initial begin
		dir_row_t dir [] = '{
			'{REQ_QUERY, 20'h00005, 1'b0, 1, ST_NOT_FOUND, 1'b0, 16'd0},
			'{REQ_UNREF, 20'h00005, 1'b0, 1, ST_NOT_FOUND, 1'b0, 16'd0},
			'{REQ_REF, 20'h00005, 1'b0, 1, ST_NOT_FOUND, 1'b0, 16'd0},
			'{REQ_REGISTER, 20'h00000, 1'b0, 1, ST_OK, 1'b1, 16'd1},
			'{REQ_REGISTER, 20'h00000, 1'b1, 1, ST_DUP, 1'b1, 16'd1},
			'{REQ_REGISTER, 20'hFFFFF, 1'b1, 1, ST_OK, 1'b1, 16'd1},
			'{REQ_REF, 20'hFFFFF, 1'b0, 1, ST_OK, 1'b1, 16'd2},
			'{REQ_REGISTER, 20'hA5A5A, 1'b0, 0, ST_OK, 1'b0, 16'd0},
			'{REQ_UNREF, 20'h00000, 1'b0, 0, ST_OK, 1'b0, 16'd0},
			'{REQ_UNREF, 20'h00000, 1'b0, 1, ST_RANGE, 1'b1, 16'd0},
			'{REQ_QUERY, 20'h00000, 1'b0, 1, ST_OK, 1'b1, 16'd0},
			'{REQ_QUERY, 20'hFFFFF, 1'b0, 0, ST_OK, 1'b0, 16'd0},
			'{REQ_SHARE, 20'h00000, 1'b0, 0, ST_OK, 1'b0, 16'd0},
			'{REQ_RELEASE, 20'h00000, 1'b0, 0, ST_OK, 1'b0, 16'd0},
			'{REQ_RELEASE, 20'h00000, 1'b0, 0, ST_OK, 1'b0, 16'd0},
			'{REQ_UNREF, 20'hFFFFF, 1'b0, 0, ST_OK, 1'b0, 16'd0},
			'{REQ_NONE, 20'h5A5A5, 1'b1, 1, ST_OK, 1'b0, 16'd0},
			'{REQ_INIT, 20'hFFFFF, 1'b1, 1, ST_OK, 1'b0, 16'd0},
			'{REQ_QUERY, 20'hFFFFF, 1'b0, 1, ST_NOT_FOUND, 1'b0, 16'd0}
		};
		errors = 0;
		quiet = 0;
		hold_off = 0;
		tx_idle = 9;
		rx_idle = 51;
		arst_n = 1'b0;
		push = 1'b0;
		req_type = REQ_NONE;
		page_number = '0;
		fixed_flag = 1'b0;
		for (int i = 0; i < NENT; i++) begin
			tbl_valid[i] = 0;
			tbl_page[i] = '0;
			tbl_fixed[i] = 0;
			tbl_count[i] = '0;
		end
		foreach (page_pool[i])
			page_pool[i] = PAGE_W'($urandom);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir[i]) begin
			send(dir[i].r, dir[i].pg, dir[i].fx);
			if (dir[i].typed) begin
				repeat (new_results.size()) void'(pending_results.pop_back());
				new_results.delete();
				add_result(dir[i].st, dir[i].fnd, dir[i].cnt, 1'b0, '0, 1'b1);
				pending_results.push_back(new_results[0]);
			end
		end
		// fill the table, mixed fixed flags, then one more to hit table full
		for (int i = 0; i < NENT; i++)
			send(REQ_REGISTER, page_pool[i], 1'(i % 3 == 0));
		send(REQ_REGISTER, 20'h0BEEF, 1'b0);
		send(REQ_RELEASE, 20'h00000, 1'b0);
		send(REQ_RELEASE, 20'h00000, 1'b0);

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle = (ph == 0) ? 9 : (ph == 1) ? 51 : 0;
			rx_idle = (ph == 0) ? 51 : (ph == 1) ? 9 : 0;
			for (int k = 0; k < 96; k++) begin
				if (ph == 0 && k == 40)
					hold_off = 1;
				send_random();
			end
		end

		// short sequence on a fresh table with one fixed page
		send(REQ_INIT, 20'h00000, 1'b0);
		send(REQ_REGISTER, 20'h12345, 1'b0);
		send(REQ_REGISTER, 20'h54321, 1'b1);
		send(REQ_REF, 20'h12345, 1'b0);
		send(REQ_SHARE, 20'h00000, 1'b0);
		send(REQ_QUERY, 20'h54321, 1'b0);
		send(REQ_RELEASE, 20'h00000, 1'b0);
		send(REQ_UNREF, 20'h54321, 1'b0);
		send(REQ_UNREF, 20'h54321, 1'b0);
		push <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("tb_page_reference_count_table: PASS");
		else
			$display("tb_page_reference_count_table: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
